[rtl/msc_pkg.sv]
// Shared types, widths and field helpers for the moving sphere contact predictor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package msc_pkg;

  localparam int COORD_W  = 21;   // one packed Q17.4 component
  localparam int DIFF_W   = 22;   // p1-p2 or v1-v2
  localparam int SQ_W     = 44;   // |d|^2, |v|^2, -v.d
  localparam int R2_W     = 34;   // (r1+r2)^2
  localparam int PROD_W   = 88;   // 44x44 products
  localparam int ROOT_W   = 60;   // sqrt(disc * 2^32)
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int NUM_W    = 60;   // (-v.d)*2^16 - s
  localparam int TIME_W   = 32;   // Q16.16 contact time
  localparam int SCALED_W = 54;   // v1 * t

  typedef enum logic [1:0] {
    ST_CONTACT = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_APART   = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  typedef struct packed {
    logic [62:0] p1;
    logic [62:0] v1;
    status_t     status;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] dd;
    logic [SQ_W-1:0] vv;
    logic [SQ_W-1:0] nd;
    logic [R2_W-1:0] r2;
    side_t           side;
  } front_t;

  typedef struct packed {
    logic [SQ_W-1:0] nd;
    logic [SQ_W-1:0] vv;
    side_t           side;
  } mid_t;

  function automatic logic signed [COORD_W-1:0] axis_raw(input logic [62:0] w,
                                                         input int unsigned k);
    return w[COORD_W*k +: COORD_W];
  endfunction

  function automatic logic signed [DIFF_W-1:0] axis_sx(input logic [62:0] w,
                                                       input int unsigned k);
    logic [COORD_W-1:0] f;
    f = w[COORD_W*k +: COORD_W];
    return {f[COORD_W-1], f};
  endfunction

endpackage

`default_nettype wire

[rtl/msc_if.sv]
// Valid/ready channel interfaces for the pair input and the contact result.
// Standalone; the top level takes one of each.
`default_nettype none

interface msc_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] first_position;
  logic [62:0] first_velocity;
  logic [62:0] second_position;
  logic [62:0] second_velocity;
  logic [15:0] first_radius;
  logic [15:0] second_radius;

  modport source(output valid, first_position, first_velocity, second_position,
                 second_velocity, first_radius, second_radius, input ready);
  modport sink(input valid, first_position, first_velocity, second_position,
               second_velocity, first_radius, second_radius, output ready);
endinterface

interface msc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [20:0] contact_x;
  logic signed [20:0] contact_y;
  logic signed [20:0] contact_z;

  modport source(output valid, status, contact_x, contact_y, contact_z, input ready);
  modport sink(input valid, status, contact_x, contact_y, contact_z, output ready);
endinterface

`default_nettype wire

[rtl/moving_sphere_contact_predictor_core.sv]
// Moving sphere contact predictor. Takes one pair of moving spheres per cycle and
// returns a status and the first sphere's Q17.4 position at first contact. The block
// accepts a new pair every clock while the result side is ready; each pair runs from
// acceptance to its result through the 60-stage square root and the 32-stage divider
// for the contact time. A stall on the result side freezes the whole
// pipeline and holds the input ready low. Results leave in the order pairs arrive.
// Depends on msc_pkg, msc_if, msc_front, msc_mul44, msc_sqrt and msc_div.
`default_nettype none

module moving_sphere_contact_predictor_core
  import msc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  msc_in_if.sink    in_ch,
  msc_out_if.source out_ch
);

  logic                 en;

  logic                 fr_valid;
  front_t               fr_word;
  mid_t                 fr_mid;

  logic [PROD_W-1:0]    lhs_p, nsq_p, rv_p;
  mid_t                 mid_m1_r, mid_m2_r;
  logic                 vld_m1_r, vld_m2_r;

  logic [PROD_W:0]      rhs_a_r;
  logic [PROD_W-1:0]    lhs_a_r;
  mid_t                 mid_a_r;
  logic                 vld_a_r;

  logic [PROD_W+1:0]    diff_w;
  logic [PROD_W-1:0]    disc_r;
  mid_t                 mid_b_r;
  logic                 vld_b_r;

  logic                 sq_valid;
  logic [ROOT_W-1:0]    sq_root;
  mid_t                 sq_mid;

  logic [NUM_W-1:0]     num_r;
  logic [SQ_W-1:0]      vv_n_r;
  side_t                side_n_r;
  logic                 vld_n_r;

  logic                 dv_valid;
  logic [TIME_W-1:0]    dv_t;
  side_t                dv_side;

  logic signed [SCALED_W-1:0] scaled_w [3];
  logic signed [SCALED_W-1:0] scaled_r [3];
  side_t                      side_p_r;
  logic                       vld_p_r;

  logic signed [SCALED_W-1:0] biased_w [3];
  logic signed [COORD_W+17:0] pos_w    [3];
  logic signed [COORD_W-1:0]  sat_w    [3];

  status_t                    out_status_r;
  logic signed [COORD_W-1:0]  out_coord_r [3];
  logic                       out_valid_r;

  // advance everything unless a finished word is waiting
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  msc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .p1        (in_ch.first_position),
    .v1        (in_ch.first_velocity),
    .p2        (in_ch.second_position),
    .v2        (in_ch.second_velocity),
    .r1        (in_ch.first_radius),
    .r2        (in_ch.second_radius),
    .out_valid (fr_valid),
    .out_word  (fr_word)
  );

  assign fr_mid = '{nd: fr_word.nd, vv: fr_word.vv, side: fr_word.side};

  msc_mul44 u_lhs (.clk(clk), .en(en), .a(fr_word.dd), .b(fr_word.vv), .p(lhs_p));
  msc_mul44 u_nsq (.clk(clk), .en(en), .a(fr_word.nd), .b(fr_word.nd), .p(nsq_p));
  msc_mul44 u_rv  (.clk(clk), .en(en), .a({{(SQ_W-R2_W){1'b0}}, fr_word.r2}),
                   .b(fr_word.vv), .p(rv_p));

  // borrow out of rhs - lhs marks a pass-by
  assign diff_w = {1'b0, rhs_a_r} - {2'b00, lhs_a_r};

  always_ff @(posedge clk) begin
    if (en) begin
      mid_m1_r <= fr_mid;
      mid_m2_r <= mid_m1_r;
      rhs_a_r  <= {1'b0, nsq_p} + {1'b0, rv_p};
      lhs_a_r  <= lhs_p;
      mid_a_r  <= mid_m2_r;
      disc_r   <= diff_w[PROD_W-1:0];
      mid_b_r  <= mid_a_r;
      if (mid_a_r.side.status == ST_CONTACT && diff_w[PROD_W+1]) begin
        mid_b_r.side.status <= ST_MISS;
      end
    end
  end

  msc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_b_r),
    .radicand  ({disc_r, {(RAD_W-PROD_W){1'b0}}}),
    .in_mid    (mid_b_r),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_mid   (sq_mid)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= {sq_mid.nd, 16'h0000} - NUM_W'(sq_root);
      vv_n_r   <= sq_mid.vv;
      side_n_r <= sq_mid.side;
    end
  end

  msc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_n_r),
    .num       (num_r),
    .den       (vv_n_r),
    .in_side   (side_n_r),
    .out_valid (dv_valid),
    .t         (dv_t),
    .out_side  (dv_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled_w[i] = SCALED_W'(axis_raw(dv_side.v1, i)) * SCALED_W'($signed({1'b0, dv_t}));
      // round half up, then floor by 2^16
      biased_w[i] = scaled_r[i] + SCALED_W'(32768);
      pos_w[i]    = (COORD_W+18)'(axis_raw(side_p_r.p1, i))
                  + (COORD_W+18)'($signed(biased_w[i][SCALED_W-1:16]));
      if (pos_w[i] > (COORD_W+18)'(1048575)) begin
        sat_w[i] = COORD_W'(1048575);
      end else if (pos_w[i] < -(COORD_W+18)'(1048576)) begin
        sat_w[i] = COORD_W'(-1048576);
      end else begin
        sat_w[i] = pos_w[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        scaled_r[i]    <= scaled_w[i];
        out_coord_r[i] <= (side_p_r.status == ST_CONTACT) ? sat_w[i] : '0;
      end
      side_p_r     <= dv_side;
      out_status_r <= side_p_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m1_r    <= 1'b0;
      vld_m2_r    <= 1'b0;
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_n_r     <= 1'b0;
      vld_p_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_m1_r    <= fr_valid;
      vld_m2_r    <= vld_m1_r;
      vld_a_r     <= vld_m2_r;
      vld_b_r     <= vld_a_r;
      vld_n_r     <= sq_valid;
      vld_p_r     <= dv_valid;
      out_valid_r <= vld_p_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.contact_x = out_coord_r[0];
  assign out_ch.contact_y = out_coord_r[1];
  assign out_ch.contact_z = out_coord_r[2];

`ifndef SYNTHESIS
  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_CONTACT
      |-> out_coord_r[0] == '0 && out_coord_r[1] == '0 && out_coord_r[2] == '0)
    else $error("contact coordinates nonzero without a predicted contact");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid && sq_mid.side.status == ST_CONTACT
      |-> NUM_W'(sq_root) <= {sq_mid.nd, 16'h0000})
    else $error("square root exceeds the scaled approach rate");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_valid) && $stable(sq_valid) && $stable(dv_t))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

[rtl/msc_front.sv]
// Front end: differences, squares, dot product, radius sum and early classification.
// Four register stages; uses msc_pkg.
`default_nettype none

module msc_front
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [62:0] p1,
  input  logic [62:0] v1,
  input  logic [62:0] p2,
  input  logic [62:0] v2,
  input  logic [15:0] r1,
  input  logic [15:0] r2,
  output logic        out_valid,
  output front_t      out_word
);

  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [DIFF_W-1:0] v_r [3];
  logic [16:0]              rsum_r;
  logic [125:0]             pv1_r, pv2_r, pv3_r;

  logic signed [SQ_W-1:0]   dsq_w [3];
  logic signed [SQ_W-1:0]   vsq_w [3];
  logic signed [SQ_W-1:0]   dv_w  [3];
  logic [SQ_W-2:0]          dsq_r [3];
  logic [SQ_W-2:0]          vsq_r [3];
  logic signed [SQ_W-1:0]   dv_r  [3];
  logic [R2_W-1:0]          r2_r2, r2_r3;

  logic [SQ_W-1:0]          dd_r3, vv_r3;
  logic signed [45:0]       dot_r3;
  logic signed [45:0]       ndot_w;
  status_t                  st_w;

  logic                     vld1_r, vld2_r, vld3_r, vld4_r;
  front_t                   out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsq_w[i] = SQ_W'(d_r[i]) * SQ_W'(d_r[i]);
      vsq_w[i] = SQ_W'(v_r[i]) * SQ_W'(v_r[i]);
      dv_w[i]  = SQ_W'(d_r[i]) * SQ_W'(v_r[i]);
    end
  end

  always_comb begin
    ndot_w = -dot_r3;
    if (dd_r3 <= {{(SQ_W-R2_W){1'b0}}, r2_r3}) begin
      st_w = ST_OVERLAP;
    end else if ((!dot_r3[45] && dot_r3 != '0) || vv_r3 == '0) begin
      st_w = ST_APART;
    end else begin
      st_w = ST_CONTACT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= axis_sx(p1, i) - axis_sx(p2, i);
        v_r[i]   <= axis_sx(v1, i) - axis_sx(v2, i);
        dsq_r[i] <= dsq_w[i][SQ_W-2:0];
        vsq_r[i] <= vsq_w[i][SQ_W-2:0];
        dv_r[i]  <= dv_w[i];
      end
      rsum_r <= {1'b0, r1} + {1'b0, r2};
      pv1_r  <= {p1, v1};
      r2_r2  <= R2_W'(rsum_r) * R2_W'(rsum_r);
      pv2_r  <= pv1_r;
      dd_r3  <= {1'b0, dsq_r[0]} + {1'b0, dsq_r[1]} + {1'b0, dsq_r[2]};
      vv_r3  <= {1'b0, vsq_r[0]} + {1'b0, vsq_r[1]} + {1'b0, vsq_r[2]};
      dot_r3 <= 46'(dv_r[0]) + 46'(dv_r[1]) + 46'(dv_r[2]);
      r2_r3  <= r2_r2;
      pv3_r  <= pv2_r;
      out_r.dd          <= dd_r3;
      out_r.vv          <= vv_r3;
      out_r.nd          <= ndot_w[SQ_W-1:0];
      out_r.r2          <= r2_r3;
      out_r.side.p1     <= pv3_r[125:63];
      out_r.side.v1     <= pv3_r[62:0];
      out_r.side.status <= st_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign out_valid = vld4_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire

[rtl/msc_mul44.sv]
// Two-stage 44x44 unsigned multiplier built from four 22x22 partial products.
// Uses msc_pkg widths.
`default_nettype none

module msc_mul44
  import msc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   a,
  input  logic [SQ_W-1:0]   b,
  output logic [PROD_W-1:0] p
);

  localparam int HW = SQ_W / 2;

  logic [SQ_W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= SQ_W'(a[HW-1:0])    * SQ_W'(b[HW-1:0]);
      lh_r <= SQ_W'(a[HW-1:0])    * SQ_W'(b[SQ_W-1:HW]);
      hl_r <= SQ_W'(a[SQ_W-1:HW]) * SQ_W'(b[HW-1:0]);
      hh_r <= SQ_W'(a[SQ_W-1:HW]) * SQ_W'(b[SQ_W-1:HW]);
      p_r  <= {hh_r, {SQ_W{1'b0}}}
            + ((PROD_W'(lh_r) + PROD_W'(hl_r)) << HW)
            + PROD_W'(ll_r);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

[rtl/msc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries the pair's side data alongside; uses msc_pkg.
`default_nettype none

module msc_sqrt
  import msc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  input  mid_t              in_mid,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output mid_t              out_mid
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r   [ROOT_W-1];
  logic [RAD_W-1:0]  rad_r   [ROOT_W-1];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  mid_t              mid_r   [ROOT_W];
  logic              valid_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_in, cur, trial;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    mid_t              mid_in;
    logic              vld_in, take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = radicand;
      assign root_in = '0;
      assign mid_in  = in_mid;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
      assign mid_in  = mid_r[k-1];
      assign vld_in  = valid_r[k-1];
    end

    // bring down the next digit pair and try (4*root + 1)
    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[ROOT_W-2:0], take};
        mid_r[k]  <= mid_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (cur - trial) : cur;
          rad_r[k] <= {rad_in[RAD_W-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= vld_in;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign out_mid   = mid_r[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/msc_div.sv]
// Pipelined restoring divider for the contact time, one quotient bit per stage,
// saturating to the Q16.16 maximum. Uses msc_pkg.
`default_nettype none

module msc_div
  import msc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [SQ_W-1:0]   den,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [TIME_W-1:0] t,
  output side_t             out_side
);

  localparam int HI_W = NUM_W - TIME_W;

  logic [SQ_W-1:0]   rem_r   [TIME_W-1];
  logic [TIME_W-1:0] low_r   [TIME_W-1];
  logic [SQ_W-1:0]   den_r   [TIME_W-1];
  logic [TIME_W-1:0] q_r     [TIME_W];
  logic              sat_r   [TIME_W];
  side_t             side_r  [TIME_W];
  logic              valid_r [TIME_W];

  for (genvar k = 0; k < TIME_W; k++) begin : g_step
    logic [SQ_W-1:0]   rem_in, den_in;
    logic [SQ_W:0]     cur;
    logic [TIME_W-1:0] low_in, q_in;
    logic              sat_in, vld_in, take;
    side_t             side_in;

    if (k == 0) begin : g_first
      assign rem_in  = SQ_W'(num[NUM_W-1:TIME_W]);
      assign low_in  = num[TIME_W-1:0];
      assign den_in  = den;
      assign q_in    = '0;
      // quotient needs more than TIME_W bits
      assign sat_in  = ({{(SQ_W-HI_W){1'b0}}, num[NUM_W-1:TIME_W]} >= den);
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign sat_in  = sat_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = valid_r[k-1];
    end

    assign cur  = {rem_in, low_in[TIME_W-1]};
    assign take = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {q_in[TIME_W-2:0], take};
        sat_r[k]  <= sat_in;
        side_r[k] <= side_in;
      end
    end

    if (k < TIME_W - 1) begin : g_carry
      logic [SQ_W:0] diff;
      assign diff = cur - {1'b0, den_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? diff[SQ_W-1:0] : cur[SQ_W-1:0];
          low_r[k] <= {low_in[TIME_W-2:0], 1'b0};
          den_r[k] <= den_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= vld_in;
      end
    end
  end

  assign out_valid = valid_r[TIME_W-1];
  assign t         = sat_r[TIME_W-1] ? '1 : q_r[TIME_W-1];
  assign out_side  = side_r[TIME_W-1];

endmodule

`default_nettype wire
